### hdl/signature_tick_stream_checker_defines.svh
// ----------------------------------------------------------------------------
// Signature tick stream checker: assertion macros
// Shared concurrent assertion shorthands. The including module must have
// clk and arst_n in scope. Define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef SIGNATURE_TICK_STREAM_CHECKER_DEFINES_SVH
`define SIGNATURE_TICK_STREAM_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge outside reset
`define STSC_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("stsc assertion failed");

// pre implies post in the same cycle
`define STSC_ASSERT_IMPLIES(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("stsc assertion failed");

`else

`define STSC_ASSERT_ALWAYS(label, cond)
`define STSC_ASSERT_IMPLIES(label, pre, post)

`endif

`endif

### hdl/stsc_pkg.sv
// ----------------------------------------------------------------------------
// Signature tick stream checker package
// Result word type, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package stsc_pkg;

	localparam int PRICE_W   = 48;
	localparam int CNT_W     = 32;
	localparam int CFG_W     = 27;
	localparam int CFG_IDX_W = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_GOLDEN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MARKER      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_PRICE = 2'd2;

	// reset values
	localparam logic [7:0]                GOLDEN_RST = 8'h00;
	localparam logic [7:0]                MARKER_RST = 8'hAA;
	localparam logic signed [PRICE_W-1:0] PRICE_RST  = 48'sd10000;

	// pattern byte: bit 7 gives the direction, low seven bits the step
	localparam int DIR_BIT = 7;
	localparam int MAG_W   = 7;

	typedef struct packed {
		logic                       is_marker;
		logic                       marker_ok;
		logic [7:0]                 cycle_index;
		logic [7:0]                 pattern_value;
		logic [7:0]                 signature_value;
		logic signed [PRICE_W-1:0]  price_cents;
		logic                       sig_checked;
		logic                       sig_ok;
		logic [CNT_W-1:0]           check_count;
		logic [CNT_W-1:0]           failure_count;
	} stsc_result_t;

endpackage

### hdl/stsc_if.sv
// ----------------------------------------------------------------------------
// Signature tick stream checker channels
// Valid/ready channels for received bytes and for result words.
// ----------------------------------------------------------------------------

// received byte channel
interface stsc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// result word channel
interface stsc_res_if;
	logic                       valid;
	logic                       ready;
	stsc_pkg::stsc_result_t     res;

	modport source (output valid, output res, input ready);
	modport sink   (input valid, input res, output ready);
endinterface

### hdl/signature_tick_stream_checker.sv
// An accepted byte waits in the input register; when it advances, any word that it yields
// is written to the result register. Throughput: one byte per cycle while ready is high.
// Pattern bytes give no word, signature and marker bytes one.
// Input register and result register each hold one word; ready drops only when both are full
// and the result word is not taken.
// Reset (arst_n low): framing restarts at a pattern byte, price 10000, counters 0,
// golden 0, marker 0xAA; no reset sweep, the block accepts at once.
// ----------------------------------------------------------------------------
// Signature tick stream checker
// Frames link bytes into (pattern, signature) pairs with a marker byte after
// every PERIOD_PAIRS pairs, tracks a saturating price and checks each period's last signature.
// ----------------------------------------------------------------------------
`include "signature_tick_stream_checker_defines.svh"

module signature_tick_stream_checker #(
	parameter int PERIOD_PAIRS = 255
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	stsc_rx_if.sink                               rx_ch,
	stsc_res_if.source                            res_ch,
	input  logic                                  cfg_we,
	input  logic [stsc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [stsc_pkg::CFG_W-1:0]            cfg_data
);

	localparam logic [7:0] PERIOD_LEN = 8'(PERIOD_PAIRS);
	localparam logic [7:0] LAST_PAIR  = 8'(PERIOD_PAIRS - 1);
	localparam int         PW         = stsc_pkg::PRICE_W;
	localparam int         CW         = stsc_pkg::CNT_W;

	// configuration registers
	logic [7:0] golden_q;
	logic [7:0] marker_q;

	// framing and accumulator state
	logic                 phase_q;
	logic [7:0]           pair_count_q;
	logic [7:0]           held_pattern_q;
	logic signed [PW-1:0] price_q;
	logic [CW-1:0]        checks_q;
	logic [CW-1:0]        failures_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic                   res_valid_q;
	stsc_pkg::stsc_result_t res_q;

	// per-word logic
	logic                   is_mark;
	logic                   produces;
	logic                   advance_s1;
	logic                   is_last;
	logic                   sig_match;
	logic [PW:0]            mag_ext;
	logic signed [PW:0]     sum_ext;
	logic signed [PW-1:0]   price_next;
	logic [CW-1:0]          checks_next;
	logic [CW-1:0]          failures_next;
	stsc_pkg::stsc_result_t res_next;

	// handshake
	assign is_mark    = !phase_q && (pair_count_q >= PERIOD_LEN);
	assign produces   = phase_q || is_mark;
	assign advance_s1 = valid_s1 && (!produces || !res_valid_q || res_ch.ready);
	assign rx_ch.ready = !valid_s1 || advance_s1;

	assign res_ch.valid = res_valid_q;
	assign res_ch.res   = res_q;

	// price step with saturation at the signed bounds
	always_comb begin
		mag_ext = {{(PW + 1 - stsc_pkg::MAG_W){1'b0}}, held_pattern_q[stsc_pkg::MAG_W-1:0]};
		if (held_pattern_q[stsc_pkg::DIR_BIT]) begin
			sum_ext = {price_q[PW-1], price_q} + $signed(mag_ext);
		end else begin
			sum_ext = {price_q[PW-1], price_q} - $signed(mag_ext);
		end
		if (sum_ext[PW] != sum_ext[PW-1]) begin
			price_next = sum_ext[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
		end else begin
			price_next = sum_ext[PW-1:0];
		end
	end

	// signature check counters
	always_comb begin
		is_last       = (pair_count_q == LAST_PAIR);
		sig_match     = (byte_s1 == golden_q);
		checks_next   = checks_q;
		failures_next = failures_q;
		if (is_last) begin
			if (checks_q != {CW{1'b1}}) begin
				checks_next = checks_q + 1'b1;
			end
			if (!sig_match && failures_q != {CW{1'b1}}) begin
				failures_next = failures_q + 1'b1;
			end
		end
	end

	// result word
	always_comb begin
		res_next = '0;
		if (is_mark) begin
			res_next.is_marker     = 1'b1;
			res_next.marker_ok     = (byte_s1 == marker_q);
			res_next.cycle_index   = pair_count_q;
			res_next.pattern_value = byte_s1;
			res_next.price_cents   = price_q;
			res_next.check_count   = checks_q;
			res_next.failure_count = failures_q;
		end else begin
			res_next.cycle_index     = pair_count_q;
			res_next.pattern_value   = held_pattern_q;
			res_next.signature_value = byte_s1;
			res_next.price_cents     = price_next;
			res_next.sig_checked     = is_last;
			res_next.sig_ok          = is_last && sig_match;
			res_next.check_count     = checks_next;
			res_next.failure_count   = failures_next;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ch.ready) begin
			valid_s1 <= rx_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ch.ready && rx_ch.valid) begin
			byte_s1 <= rx_ch.rx_byte;
		end
	end

	// configuration writes and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			golden_q       <= stsc_pkg::GOLDEN_RST;
			marker_q       <= stsc_pkg::MARKER_RST;
			phase_q        <= 1'b0;
			pair_count_q   <= '0;
			held_pattern_q <= '0;
			price_q        <= stsc_pkg::PRICE_RST;
			checks_q       <= '0;
			failures_q     <= '0;
		end else begin
			if (advance_s1) begin
				if (is_mark) begin
					pair_count_q <= '0;
				end else if (!phase_q) begin
					held_pattern_q <= byte_s1;
					phase_q        <= 1'b1;
				end else begin
					phase_q      <= 1'b0;
					pair_count_q <= pair_count_q + 1'b1;
					price_q      <= price_next;
					checks_q     <= checks_next;
					failures_q   <= failures_next;
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					stsc_pkg::CFG_GOLDEN:      golden_q <= cfg_data[7:0];
					stsc_pkg::CFG_MARKER:      marker_q <= cfg_data[7:0];
					stsc_pkg::CFG_START_PRICE: price_q  <= {{(PW - stsc_pkg::CFG_W){1'b0}}, cfg_data};
					default: ;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance_s1 && produces) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && produces) begin
			res_q <= res_next;
		end
	end

	// checks
	`STSC_ASSERT_ALWAYS(a_fail_le_checks, failures_q <= checks_q)
	`STSC_ASSERT_ALWAYS(a_pair_in_range, pair_count_q <= PERIOD_LEN)
	`STSC_ASSERT_IMPLIES(a_check_on_last, res_valid_q && res_q.sig_checked, res_q.cycle_index == LAST_PAIR)
	`STSC_ASSERT_IMPLIES(a_marker_clean, res_valid_q && res_q.is_marker, !res_q.sig_checked && res_q.signature_value == 8'd0)

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signature tick stream checker testbench
// Drives received bytes through the valid/ready byte channel, rewrites the
// registers between phases and predicts every result word: pair framing,
// period marker, saturating price and signature counters. Result words are
// compared field by field, in order, under random sender gaps, receiver
// stalls and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int PERIOD_PAIRS = 255;
	localparam int PHASE_BYTES  = 330;
	localparam int BURST_BYTES  = 48;
	localparam int HOLD_CYCLES  = 80;
	localparam int SETTLE       = 4;
	localparam int QUIET_LIMIT  = 1000;
	localparam int MAX_PRINTS   = 40;
	localparam int CFG_W        = stsc_pkg::CFG_W;
	localparam int CFG_IDX_W    = stsc_pkg::CFG_IDX_W;
	localparam int PRICE_W      = stsc_pkg::PRICE_W;
	localparam int CNT_W        = stsc_pkg::CNT_W;
	localparam longint PRICE_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint PRICE_LO = -PRICE_HI - 1;
	localparam logic [CFG_W-1:0] START_PRICE_MAX = 27'd100000000;

	typedef struct {
		logic [7:0]             rx;
		bit                     typed;
		stsc_pkg::stsc_result_t word;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	stsc_rx_if  rx_ch();
	stsc_res_if res_ch();

	signature_tick_stream_checker #(.PERIOD_PAIRS(PERIOD_PAIRS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_ch     (rx_ch),
		.res_ch    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// framing and price tracker state
	logic [7:0]                golden_sig;
	logic [7:0]                marker_ref;
	logic                      awaiting_sig;
	logic [7:0]                pairs_done;
	logic [7:0]                pattern_hold;
	logic signed [PRICE_W-1:0] price_run;
	logic [CNT_W-1:0]          checks_run;
	logic [CNT_W-1:0]          fails_run;
	int                        markers_seen;

	stsc_pkg::stsc_result_t pending_words[$];
	dir_row_t               dir_rows[18];

	int idle_pct;
	int stall_pct;
	int hold_reqs;
	int holds_done;
	int hold_left;
	int err_count;
	int words_seen;
	int quiet_cycles;

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic stsc_pkg::stsc_result_t word_of(input logic mk, input logic mok,
			input logic [7:0] idx, input logic [7:0] pat, input logic [7:0] sig,
			input logic signed [PRICE_W-1:0] price, input logic chk, input logic sok,
			input logic [CNT_W-1:0] chks, input logic [CNT_W-1:0] fls);
		stsc_pkg::stsc_result_t w;
		w.is_marker       = mk;
		w.marker_ok       = mok;
		w.cycle_index     = idx;
		w.pattern_value   = pat;
		w.signature_value = sig;
		w.price_cents     = price;
		w.sig_checked     = chk;
		w.sig_ok          = sok;
		w.check_count     = chks;
		w.failure_count   = fls;
		return w;
	endfunction

	// advance the tracker by one byte; returns 1 when the byte yields a word
	function automatic bit frame_and_price(input logic [7:0] b,
			output stsc_pkg::stsc_result_t w);
		longint nxt;
		logic   chk;
		logic   sok;
		w = '0;
		if (!awaiting_sig) begin
			// marker slot takes any byte
			if (pairs_done >= PERIOD_PAIRS) begin
				w = word_of(1'b1, b == marker_ref, pairs_done, b, 8'h00, price_run,
					1'b0, 1'b0, checks_run, fails_run);
				pairs_done = '0;
				markers_seen++;
				return 1'b1;
			end
			pattern_hold = b;
			awaiting_sig = 1'b1;
			return 1'b0;
		end
		// signature byte closes the pair: move price, saturate at 48 bits
		nxt = price_run;
		if (pattern_hold[stsc_pkg::DIR_BIT])
			nxt = nxt + longint'(pattern_hold[stsc_pkg::MAG_W-1:0]);
		else
			nxt = nxt - longint'(pattern_hold[stsc_pkg::MAG_W-1:0]);
		if (nxt > PRICE_HI)
			nxt = PRICE_HI;
		if (nxt < PRICE_LO)
			nxt = PRICE_LO;
		price_run = nxt[PRICE_W-1:0];
		// last pair of the period checks the signature
		chk = (pairs_done == PERIOD_PAIRS - 1);
		sok = 1'b0;
		if (chk) begin
			if (checks_run != '1)
				checks_run++;
			if (b == golden_sig)
				sok = 1'b1;
			else if (fails_run != '1)
				fails_run++;
		end
		w = word_of(1'b0, 1'b0, pairs_done, pattern_hold, b, price_run, chk, sok,
			checks_run, fails_run);
		pairs_done++;
		awaiting_sig = 1'b0;
		return 1'b1;
	endfunction

	// random byte; period-end slots alternate between matching and not
	function automatic logic [7:0] next_rx();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (!awaiting_sig && pairs_done >= PERIOD_PAIRS) begin
			if (markers_seen % 2 == 0)
				b = marker_ref;
			else if (b == marker_ref)
				b = ~marker_ref;
		end else if (awaiting_sig && pairs_done == PERIOD_PAIRS - 1) begin
			if (checks_run[0] == 1'b0)
				b = golden_sig;
			else if (b == golden_sig)
				b = ~golden_sig;
		end
		return b;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("word %0d: %s got %0h want %0h", words_seen, what, got, want);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	task automatic check_word(input stsc_pkg::stsc_result_t got);
		stsc_pkg::stsc_result_t want;
		words_seen++;
		if (pending_words.size() == 0) begin
			report_mismatch("word with none expected", got.pattern_value, 64'd0);
			return;
		end
		want = pending_words.pop_front();
		check_field("is_marker", got.is_marker, want.is_marker);
		check_field("marker_ok", got.marker_ok, want.marker_ok);
		check_field("cycle_index", got.cycle_index, want.cycle_index);
		check_field("pattern_value", got.pattern_value, want.pattern_value);
		check_field("signature_value", got.signature_value, want.signature_value);
		check_field("price_cents", got.price_cents, want.price_cents);
		check_field("sig_checked", got.sig_checked, want.sig_checked);
		check_field("sig_ok", got.sig_ok, want.sig_ok);
		check_field("check_count", got.check_count, want.check_count);
		check_field("failure_count", got.failure_count, want.failure_count);
	endtask

	// offer one byte, predict on acceptance; typed rows override the prediction
	task automatic send_byte(input logic [7:0] b, input bit typed,
			input stsc_pkg::stsc_result_t typed_word);
		stsc_pkg::stsc_result_t w;
		while ($urandom_range(99) < idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
		if (frame_and_price(b, w)) begin
			if (typed)
				w = typed_word;
			pending_words = {pending_words, w};
		end
	endtask

	// write all three registers back to back
	task automatic write_regs(input logic [7:0] golden, input logic [7:0] marker,
			input logic [CFG_W-1:0] price);
		cfg_we    <= 1'b1;
		cfg_index <= stsc_pkg::CFG_GOLDEN;
		cfg_data  <= CFG_W'(golden);
		@(posedge clk);
		golden_sig = golden;
		cfg_index <= stsc_pkg::CFG_MARKER;
		cfg_data  <= CFG_W'(marker);
		@(posedge clk);
		marker_ref = marker;
		cfg_index <= stsc_pkg::CFG_START_PRICE;
		cfg_data  <= price;
		@(posedge clk);
		price_run = PRICE_W'(price);
		cfg_we <= 1'b0;
	endtask

	// stop sending, wait for every expected word, then let the pipe settle
	task automatic drain();
		rx_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// receiver: random stalls, plus long hold-offs on request
	initial res_ch.ready = 1'b0;
	always @(posedge clk) begin
		if (hold_reqs != holds_done) begin
			hold_left    <= HOLD_CYCLES;
			holds_done   <= holds_done + 1;
			res_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			check_word(res_ch.res);
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int ph;
		int n;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		idle_pct      = 0;
		stall_pct     = 0;
		hold_reqs     = 0;
		holds_done    = 0;
		hold_left     = 0;
		err_count     = 0;
		words_seen    = 0;
		quiet_cycles  = 0;
		golden_sig    = stsc_pkg::GOLDEN_RST;
		marker_ref    = stsc_pkg::MARKER_RST;
		awaiting_sig  = 1'b0;
		pairs_done    = '0;
		pattern_hold  = '0;
		price_run     = stsc_pkg::PRICE_RST;
		checks_run    = '0;
		fails_run     = '0;
		markers_seen  = 0;

		// directed rows from reset: step extremes in both directions, then mixed
		dir_rows = '{
			'{8'hFF, 1'b0, '0},
			'{8'h00, 1'b1, word_of(1'b0, 1'b0, 8'd0, 8'hFF, 8'h00, 48'sd10127,
				1'b0, 1'b0, 32'd0, 32'd0)},
			'{8'h00, 1'b0, '0},
			'{8'hFF, 1'b1, word_of(1'b0, 1'b0, 8'd1, 8'h00, 8'hFF, 48'sd10127,
				1'b0, 1'b0, 32'd0, 32'd0)},
			'{8'h7F, 1'b0, '0},
			'{8'h55, 1'b1, word_of(1'b0, 1'b0, 8'd2, 8'h7F, 8'h55, 48'sd10000,
				1'b0, 1'b0, 32'd0, 32'd0)},
			'{8'h80, 1'b0, '0},
			'{8'hAA, 1'b1, word_of(1'b0, 1'b0, 8'd3, 8'h80, 8'hAA, 48'sd10000,
				1'b0, 1'b0, 32'd0, 32'd0)},
			'{8'h01, 1'b0, '0},
			'{8'hFE, 1'b0, '0},
			'{8'h81, 1'b0, '0},
			'{8'h01, 1'b0, '0},
			'{8'hC3, 1'b0, '0},
			'{8'h3C, 1'b0, '0},
			'{8'hAA, 1'b0, '0},
			'{8'hAA, 1'b0, '0},
			'{8'h5A, 1'b0, '0},
			'{8'hA5, 1'b0, '0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].word);

		// random phases, registers rewritten while idle
		for (ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin
					write_regs(8'hFF, 8'h00, '0);
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					write_regs(8'($urandom_range(255)), 8'hFF, START_PRICE_MAX);
					idle_pct  = 64;
					stall_pct = 0;
				end
				2: begin
					write_regs(8'h00, 8'($urandom_range(255)),
						CFG_W'($urandom_range(100000000)));
					idle_pct  = 0;
					stall_pct = 64;
				end
				default: begin
					write_regs(8'($urandom_range(255)), stsc_pkg::MARKER_RST, 27'd10000);
					idle_pct  = 13;
					stall_pct = 13;
				end
			endcase
			for (n = 0; n < PHASE_BYTES; n++)
				send_byte(next_rx(), 1'b0, '0);
		end

		// back-pressure: receiver holds off while bytes keep coming
		drain();
		idle_pct  = 0;
		stall_pct = 0;
		hold_reqs++;
		for (n = 0; n < BURST_BYTES; n++)
			send_byte(next_rx(), 1'b0, '0);
		drain();

		if (err_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
